FILE: hw/rtl/kso_pkg.sv
// ----------------------------------------------------------------------------
// kso_pkg: shared types and constants of the k-choice online selector
// Field widths, configuration register indexes and the structs that pass
// between the cell chain and the top level.
// ----------------------------------------------------------------------------
package kso_pkg;

	localparam int VALUE_W    = 32;
	localparam int K_REG_W    = 7;
	localparam int SAMPLE_W   = 17;
	localparam int TAKEN_W    = 17;
	localparam int ACC_W      = 48;
	localparam int SUM_W      = 38;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_K_TARGET     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd1;

	localparam logic [TAKEN_W-1:0] TAKEN_MAX = {TAKEN_W{1'b1}};
	localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};

	// What one cell shows its right-hand neighbor.
	typedef struct packed {
		logic               keep;
		logic [VALUE_W-1:0] value;
		logic               sample;
		logic [SUM_W-1:0]   prefix;
	} kso_link_t;

	// Decision inputs and the new top-k sum, from the chain to the top level.
	typedef struct packed {
		logic             below_k;
		logic             beats_thr;
		logic             thr_sample;
		logic [SUM_W-1:0] best_sum;
	} kso_status_t;

endpackage

FILE: hw/rtl/kso_ifs.sv
// ----------------------------------------------------------------------------
// kso_ifs: channel interfaces of the k-choice online selector
// Offer input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface kso_offer_if;
	import kso_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] offer_value;
	logic               last_of_run;
	modport source (output valid, output offer_value, output last_of_run, input ready);
	modport sink (input valid, input offer_value, input last_of_run, output ready);
endinterface

interface kso_result_if;
	import kso_pkg::*;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [TAKEN_W-1:0] taken_count;
	logic [ACC_W-1:0]   accepted_sum;
	logic [SUM_W-1:0]   best_k_sum;
	logic               run_done;
	modport source (output valid, output accepted, output taken_count, output accepted_sum,
		output best_k_sum, output run_done, input ready);
	modport sink (input valid, input accepted, input taken_count, input accepted_sum,
		input best_k_sum, input run_done, output ready);
endinterface

interface kso_cfg_if;
	import kso_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/kso_cell.sv
// ----------------------------------------------------------------------------
// kso_cell: one entry of the sorted top list
// Holds a value, its sample-phase tag and the running prefix sum of all
// entries up to and including this one. On insertion the cell either holds,
// takes the new value, or takes its left neighbor's entry.
// ----------------------------------------------------------------------------
module kso_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [kso_pkg::VALUE_W-1:0] v,
	input  logic                        v_sample,
	input  logic                        valid,
	input  kso_pkg::kso_link_t          left,
	output kso_pkg::kso_link_t          link,
	output logic [kso_pkg::SUM_W-1:0]   next_prefix
);
	import kso_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic               sample_q;
	logic [SUM_W-1:0]   prefix_q;
	logic               keep;
	logic [VALUE_W-1:0] next_value;
	logic               next_sample;

	// A stored value that ties the new one moves down: the new item ranks above.
	assign keep = valid && (value_q > v);

	always_comb begin
		if (keep) begin
			next_value  = value_q;
			next_sample = sample_q;
			next_prefix = prefix_q;
		end else begin
			next_value  = left.keep ? v : left.value;
			next_sample = left.keep ? v_sample : left.sample;
			next_prefix = left.prefix + SUM_W'(v);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q  <= next_value;
			sample_q <= next_sample;
			prefix_q <= next_prefix;
		end
	end

	assign link = '{keep: keep, value: value_q, sample: sample_q, prefix: prefix_q};

endmodule

FILE: hw/rtl/kso_chain.sv
// ----------------------------------------------------------------------------
// kso_chain: row of sorted-list cells with fill count and selection
// Inserts one value per transfer, tracks how many entries are valid and picks
// the threshold entry and the new top-k prefix sum.
// ----------------------------------------------------------------------------
module kso_chain #(
	parameter int MAX_K = 64,
	parameter int KW    = $clog2(MAX_K + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        clear,
	input  logic [kso_pkg::VALUE_W-1:0] v,
	input  logic                        v_sample,
	input  logic [KW-1:0]               eff_k,
	output kso_pkg::kso_status_t        status
);
	import kso_pkg::*;

	logic [KW-1:0]      fill_q;
	logic [KW-1:0]      fill_new;
	logic [KW-1:0]      used;
	kso_link_t          link_in  [MAX_K];
	kso_link_t          link_out [MAX_K];
	logic [SUM_W-1:0]   nprefix  [MAX_K];
	logic [VALUE_W-1:0] thr_value;
	logic               thr_sample;
	logic [SUM_W-1:0]   best_sum;

	assign link_in[0] = '{keep: 1'b1, value: '0, sample: 1'b0, prefix: '0};

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign link_in[i] = link_out[i-1];
		end
		kso_cell u_cell (
			.clk        (clk),
			.en         (en),
			.v          (v),
			.v_sample   (v_sample),
			.valid      (KW'(i) < fill_q),
			.left       (link_in[i]),
			.link       (link_out[i]),
			.next_prefix(nprefix[i])
		);
	end

	assign fill_new = (fill_q < KW'(MAX_K)) ? fill_q + KW'(1) : fill_q;
	assign used     = (eff_k < fill_new) ? eff_k : fill_new;

	always_comb begin
		thr_value  = '0;
		thr_sample = 1'b0;
		best_sum   = '0;
		for (int i = 0; i < MAX_K; i++) begin
			if (KW'(i) == eff_k - KW'(1)) begin
				thr_value  = thr_value | link_out[i].value;
				thr_sample = thr_sample | link_out[i].sample;
			end
			if (KW'(i) == used - KW'(1)) begin
				best_sum = best_sum | nprefix[i];
			end
		end
	end

	assign status = '{below_k: fill_q < eff_k, beats_thr: v > thr_value,
		thr_sample: thr_sample, best_sum: best_sum};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (en) begin
			fill_q <= clear ? '0 : fill_new;
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= KW'(MAX_K))
		else $error("fill count beyond list depth");
	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		en && clear |=> fill_q == '0)
		else $error("list not emptied after end of run");
	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		en && !clear && fill_q < KW'(MAX_K) |=> fill_q == $past(fill_q) + KW'(1))
		else $error("fill count did not follow an insertion");
`endif

endmodule

FILE: hw/rtl/k_secretary_online_selector.sv
// ----------------------------------------------------------------------------
// k_secretary_online_selector: k-choice online selector with sample threshold
// Keeps the k largest offers of a run in a sorted cell chain; past the sample
// phase it accepts below k entries or above a k-th entry taken in the sample.
// ----------------------------------------------------------------------------
// One offer is taken every clock cycle and its result is written to the output
// register at the transfer. Offers keep flowing while that result waits as long
// as it is taken in the same cycle; a stalled result holds the offer side. The
// rate is set by the chain of MAX_K cells, which compares every stored value
// against the new offer and shifts the whole list at once, each cell also
// updating its prefix sum with one adder.
// After reset and after the last offer of a run the list is empty at once;
// there is no clearing pass. Configuration writes are always ready.
module k_secretary_online_selector #(
	parameter int MAX_K     = 64,
	parameter int MAX_ITEMS = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	kso_offer_if.sink     offer,
	kso_result_if.source  result,
	kso_cfg_if.sink       cfg
);
	import kso_pkg::*;

	localparam int KW  = $clog2(MAX_K + 1);
	localparam int EW  = (KW > K_REG_W) ? KW : K_REG_W;
	localparam int IXW = $clog2(MAX_ITEMS + 1);
	localparam int CW  = (IXW > SAMPLE_W) ? IXW : SAMPLE_W;

	logic [K_REG_W-1:0]  k_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [IXW-1:0]      item_q;
	logic [TAKEN_W-1:0]  taken_q;
	logic [ACC_W-1:0]    acc_sum_q;

	logic                out_valid_q;
	logic                accepted_q;
	logic [TAKEN_W-1:0]  taken_count_q;
	logic [ACC_W-1:0]    accepted_sum_q;
	logic [SUM_W-1:0]    best_k_sum_q;
	logic                run_done_q;

	logic [EW-1:0]       k_ext;
	logic [KW-1:0]       eff_k;
	logic                xfer;
	logic                in_sample;
	logic                acc;
	logic [TAKEN_W-1:0]  taken_next;
	logic [ACC_W:0]      acc_sum_wide;
	logic [ACC_W-1:0]    acc_sum_next;
	kso_status_t         status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= K_REG_W'(1);
			sample_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_K_TARGET:     k_q      <= cfg.data[K_REG_W-1:0];
				REG_SAMPLE_COUNT: sample_q <= cfg.data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// A k of zero acts as one; a k beyond the list depth acts as the depth.
	assign k_ext = EW'(k_q);
	always_comb begin
		if (k_q == '0) begin
			eff_k = KW'(1);
		end else if (k_ext > EW'(MAX_K)) begin
			eff_k = KW'(MAX_K);
		end else begin
			eff_k = KW'(k_ext);
		end
	end

	assign offer.ready = !out_valid_q || result.ready;
	assign xfer        = offer.valid && offer.ready;
	assign in_sample   = CW'(item_q) < CW'(sample_q);

	kso_chain #(.MAX_K(MAX_K), .KW(KW)) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (xfer),
		.clear   (offer.last_of_run),
		.v       (offer.offer_value),
		.v_sample(in_sample),
		.eff_k   (eff_k),
		.status  (status)
	);

	assign acc = !in_sample && (status.below_k || (status.beats_thr && status.thr_sample));

	assign taken_next   = (acc && taken_q != TAKEN_MAX) ? taken_q + TAKEN_W'(1) : taken_q;
	assign acc_sum_wide = {1'b0, acc_sum_q} + (ACC_W + 1)'(offer.offer_value);
	always_comb begin
		if (!acc) begin
			acc_sum_next = acc_sum_q;
		end else if (acc_sum_wide[ACC_W]) begin
			acc_sum_next = ACC_MAX;
		end else begin
			acc_sum_next = acc_sum_wide[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q    <= '0;
			taken_q   <= '0;
			acc_sum_q <= '0;
		end else if (xfer) begin
			if (offer.last_of_run) begin
				item_q    <= '0;
				taken_q   <= '0;
				acc_sum_q <= '0;
			end else begin
				if (item_q != IXW'(MAX_ITEMS)) begin
					item_q <= item_q + IXW'(1);
				end
				taken_q   <= taken_next;
				acc_sum_q <= acc_sum_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			accepted_q     <= acc;
			taken_count_q  <= taken_next;
			accepted_sum_q <= acc_sum_next;
			best_k_sum_q   <= status.best_sum;
			run_done_q     <= offer.last_of_run;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.accepted     = accepted_q;
	assign result.taken_count  = taken_count_q;
	assign result.accepted_sum = accepted_sum_q;
	assign result.best_k_sum   = best_k_sum_q;
	assign result.run_done     = run_done_q;

`ifndef NO_ASSERTIONS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |=> result.valid)
		else $error("no result after an offer transfer");
	a_sample_never_taken: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && in_sample |=> !result.accepted)
		else $error("offer accepted during the sample phase");
	a_sum_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.accepted_sum != '0 |-> result.taken_count != '0)
		else $error("accepted sum without an accepted offer");
	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && offer.last_of_run |=> taken_q == '0 && acc_sum_q == '0 && item_q == '0)
		else $error("run state not cleared after the last offer");
`endif

endmodule

FILE: sim/kso_checker.sv
// ----------------------------------------------------------------------------
// kso_checker: result predictor and scoreboard for the k-choice selector
// Watches the offer, result and configuration channels. Every offer transfer
// is scored against a private copy of the sorted top list. Every result
// transfer is compared field by field with the oldest outstanding outcome.
// ----------------------------------------------------------------------------
module kso_checker #(
	parameter int MAX_K     = 64,
	parameter int MAX_ITEMS = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           offer_valid,
	input  logic                           offer_ready,
	input  logic [kso_pkg::VALUE_W-1:0]    offer_value,
	input  logic                           last_of_run,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  logic                           accepted,
	input  logic [kso_pkg::TAKEN_W-1:0]    taken_count,
	input  logic [kso_pkg::ACC_W-1:0]      accepted_sum,
	input  logic [kso_pkg::SUM_W-1:0]      best_k_sum,
	input  logic                           run_done,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [kso_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kso_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                    fail_count,
	output int unsigned                    pending_count
);
	import kso_pkg::*;

	typedef struct packed {
		logic               accepted;
		logic [TAKEN_W-1:0] taken_count;
		logic [ACC_W-1:0]   accepted_sum;
		logic [SUM_W-1:0]   best_k_sum;
		logic               run_done;
	} kso_outcome_t;

	logic [K_REG_W-1:0]  k_setting;
	logic [SAMPLE_W-1:0] sample_setting;

	// Private copy of the sorted list, descending, with sample-phase tags.
	logic [VALUE_W-1:0] list_val [MAX_K];
	logic               list_from_sample [MAX_K];
	int                 list_len;
	int                 offer_pos;
	logic [TAKEN_W-1:0] sel_count;
	logic [ACC_W-1:0]   sel_sum;

	kso_outcome_t due_results [$];

	function automatic void empty_list();
		for (int i = 0; i < MAX_K; i++) begin
			list_val[i] = '0;
			list_from_sample[i] = 1'b0;
		end
		list_len = 0;
		offer_pos = 0;
		sel_count = '0;
		sel_sum = '0;
	endfunction

	function automatic kso_outcome_t score_offer(input logic [VALUE_W-1:0] value,
		input logic last);
		kso_outcome_t outcome;
		int           k_eff;
		int           slot;
		int           i;
		logic         in_sample;
		logic         take;
		logic [63:0]  total;
		k_eff = (k_setting == 0) ? 1 : ((int'(k_setting) > MAX_K) ? MAX_K : int'(k_setting));
		in_sample = offer_pos < int'(sample_setting);
		take = 1'b0;
		if (!in_sample) begin
			if (list_len < k_eff) begin
				take = 1'b1;
			end else if (value > list_val[k_eff-1] && list_from_sample[k_eff-1]) begin
				take = 1'b1;
			end
		end
		if (take) begin
			if (sel_count != TAKEN_MAX)
				sel_count = sel_count + 1'b1;
			total = 64'(sel_sum) + 64'(value);
			sel_sum = (total > 64'(ACC_MAX)) ? ACC_MAX : total[ACC_W-1:0];
		end
		// A new value goes above every stored value equal to it.
		slot = 0;
		while (slot < list_len && list_val[slot] > value)
			slot++;
		if (slot < MAX_K) begin
			i = (list_len < MAX_K) ? list_len : MAX_K - 1;
			while (i > slot) begin
				list_val[i] = list_val[i-1];
				list_from_sample[i] = list_from_sample[i-1];
				i--;
			end
			list_val[slot] = value;
			list_from_sample[slot] = in_sample;
			if (list_len < MAX_K)
				list_len++;
		end
		total = '0;
		for (i = 0; i < k_eff && i < list_len; i++)
			total = total + 64'(list_val[i]);
		if (offer_pos < MAX_ITEMS)
			offer_pos++;
		outcome.accepted = take;
		outcome.taken_count = sel_count;
		outcome.accepted_sum = sel_sum;
		outcome.best_k_sum = total[SUM_W-1:0];
		outcome.run_done = last;
		if (last)
			empty_list();
		return outcome;
	endfunction

	task automatic log_failure(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string field, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			log_failure($sformatf("%s got %0h, want %0h", field, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		kso_outcome_t want;
		if (!arst_n) begin
			k_setting = 7'd1;
			sample_setting = '0;
			empty_list();
			due_results.delete();
			fail_count = 0;
			pending_count <= 0;
		end else begin
			// Pop before push: a result never belongs to the offer of the same edge.
			if (res_valid && res_ready) begin
				if (due_results.size() == 0) begin
					log_failure("result transfer with no outcome outstanding");
				end else begin
					want = due_results.pop_front();
					compare_field("accepted", 64'(accepted), 64'(want.accepted));
					compare_field("taken_count", 64'(taken_count), 64'(want.taken_count));
					compare_field("accepted_sum", 64'(accepted_sum), 64'(want.accepted_sum));
					compare_field("best_k_sum", 64'(best_k_sum), 64'(want.best_k_sum));
					compare_field("run_done", 64'(run_done), 64'(want.run_done));
				end
			end
			if (offer_valid && offer_ready)
				due_results = {due_results, score_offer(offer_value, last_of_run)};
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_K_TARGET: k_setting = cfg_data[K_REG_W-1:0];
					REG_SAMPLE_COUNT: sample_setting = cfg_data[SAMPLE_W-1:0];
					default: ;
				endcase
			end
			pending_count <= due_results.size();
		end
	end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for the k-choice online selector
// Drives directed and random offer runs through several register settings,
// with random idle bursts on both channels, one long receiver hold-off and
// one long run that stays in the sample phase throughout. The checker scores
// every transfer; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import kso_pkg::*;

	localparam int MAX_K       = 64;
	localparam int MAX_ITEMS   = 65536;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int LONG_RUN    = 130;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum int {VAL_ANY, VAL_TIES, VAL_EDGE, VAL_RISING} value_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        idle_on;
	logic        hold_req;
	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned quiet_cycles;

	kso_offer_if  offer();
	kso_result_if result();
	kso_cfg_if    cfg();

	k_secretary_online_selector #(
		.MAX_K     (MAX_K),
		.MAX_ITEMS (MAX_ITEMS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.offer  (offer),
		.result (result),
		.cfg    (cfg)
	);

	kso_checker #(
		.MAX_K     (MAX_K),
		.MAX_ITEMS (MAX_ITEMS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.offer_valid   (offer.valid),
		.offer_ready   (offer.ready),
		.offer_value   (offer.offer_value),
		.last_of_run   (offer.last_of_run),
		.res_valid     (result.valid),
		.res_ready     (result.ready),
		.accepted      (result.accepted),
		.taken_count   (result.taken_count),
		.accepted_sum  (result.accepted_sum),
		.best_k_sum    (result.best_k_sum),
		.run_done      (result.run_done),
		.cfg_valid     (cfg.valid),
		.cfg_ready     (cfg.ready),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Ends the run when no channel has made a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n || (offer.valid && offer.ready) || (result.valid && result.ready)
			|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("k_secretary_online_selector regression: fail");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		bit hold_done;
		hold_done = 1'b0;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				result.ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				while (hold_left > 0) begin
					@(posedge clk);
					hold_left--;
				end
				hold_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				result.ready <= 1'b1;
				if (idle_on)
					repeat ($urandom_range(1, 20)) @(posedge clk);
				else
					@(posedge clk);
			end
		end
	end

	task automatic send_offer(input logic [VALUE_W-1:0] value, input logic last);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			offer.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		offer.valid <= 1'b1;
		offer.offer_value <= value;
		offer.last_of_run <= last;
		@(posedge clk);
		while (!offer.ready)
			@(posedge clk);
	endtask

	// Leaves the offer channel quiet until every outcome has been checked.
	task automatic drain();
		offer.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	// Raises valid and waits for the transfer; the caller lowers valid.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
	endtask

	// Bits above a register's width are junk half of the time.
	task automatic set_config(input logic [K_REG_W-1:0] k, input logic [SAMPLE_W-1:0] samples);
		logic [CFG_DATA_W-1:0] data;
		data = $urandom_range(0, 1) ? $urandom : '0;
		data[K_REG_W-1:0] = k;
		write_reg(REG_K_TARGET, data);
		data = $urandom_range(0, 1) ? $urandom : '0;
		data[SAMPLE_W-1:0] = samples;
		write_reg(REG_SAMPLE_COUNT, data);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [K_REG_W-1:0] pick_k();
		case ($urandom_range(0, 11))
			0: return 7'd0;
			1: return 7'd1;
			2: return 7'd2;
			3: return 7'd3;
			4: return 7'd4;
			5: return 7'd8;
			6: return 7'd63;
			7: return 7'd64;
			8: return 7'd65;
			9: return 7'd127;
			default: return K_REG_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_samples();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 17'd1;
			2: return 17'd2;
			3: return 17'd5;
			4: return 17'd65536;
			default: return SAMPLE_W'($urandom_range(0, 40));
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value(input value_style_t style,
		input logic [VALUE_W-1:0] ramp);
		case (style)
			VAL_TIES: return VALUE_W'(32'h0100_0000 * $urandom_range(0, 5));
			VAL_EDGE: return $urandom_range(0, 1) ? '1 : '0;
			VAL_RISING: return ramp;
			default: return $urandom;
		endcase
	endfunction

	// Mostly complete runs with random content; now and then a run is cut short.
	task automatic random_phase(input int count);
		int                 run_left;
		value_style_t       style;
		logic [VALUE_W-1:0] ramp;
		logic               last;
		run_left = 0;
		style = VAL_ANY;
		ramp = '0;
		for (int n = 0; n < count; n++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(1, 60);
				style = value_style_t'($urandom_range(0, 3));
				ramp = $urandom_range(0, 1 << 24);
			end
			run_left--;
			if ($urandom_range(0, 49) == 0)
				run_left = 0;
			last = (run_left == 0);
			send_offer(pick_value(style, ramp), last);
			ramp = ramp + $urandom_range(0, 1 << 22);
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		idle_on <= 1'b1;
		hold_req <= 1'b0;
		offer.valid <= 1'b0;
		offer.offer_value <= '0;
		offer.last_of_run <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_K_TARGET;
		cfg.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes and ties at reset settings.
		send_offer('0, 1'b0);
		send_offer('1, 1'b0);
		send_offer('1, 1'b0);
		send_offer(32'd1, 1'b0);
		send_offer(32'h8000_0000, 1'b1);
		drain();
		// Sample phase, then fill below k, then a threshold taken from the sample.
		set_config(7'd3, 17'd2);
		send_offer(32'd5, 1'b0);
		send_offer(32'd9, 1'b0);
		send_offer(32'd7, 1'b0);
		send_offer(32'd10, 1'b0);
		send_offer(32'd9, 1'b0);
		send_offer('1, 1'b0);
		send_offer('0, 1'b1);
		drain();
		// A zero k acts as one.
		set_config(7'd0, 17'd1);
		send_offer(32'd4, 1'b0);
		send_offer(32'd4, 1'b0);
		send_offer('0, 1'b1);
		drain();
		// A k above the list size acts as the list size.
		set_config(7'd127, 17'd0);
		send_offer('1, 1'b0);
		send_offer('0, 1'b0);
		send_offer(32'h1234_5678, 1'b1);
		drain();
		write_reg(REG_SPARE, $urandom);
		set_config(7'd65, 17'd3);
		for (int n = 1; n <= 4; n++)
			send_offer(VALUE_W'(n), 1'b0);
		drain();
		// Register change in the middle of a run.
		set_config(7'd2, 17'd0);
		send_offer(32'd6, 1'b1);
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			set_config(pick_k(), pick_samples());
			if (phase == 3)
				hold_req <= 1'b1;
			random_phase(110);
		end

		// Long run with a sample phase longer than the item limit; every item
		// stays in the sample phase, so the large values at the end are never taken.
		idle_on <= 1'b0;
		set_config(7'd4, 17'(MAX_ITEMS + 1));
		for (int n = 0; n < LONG_RUN; n++)
			send_offer((n >= LONG_RUN - 4) ? '1 : VALUE_W'($urandom), n == LONG_RUN - 1);
		drain();

		set_config(7'd64, 17'd8);
		random_phase(100);

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("k_secretary_online_selector regression: pass");
		else
			$display("k_secretary_online_selector regression: fail");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/kso_pkg.sv
hw/rtl/kso_ifs.sv
hw/rtl/kso_cell.sv
hw/rtl/kso_chain.sv
hw/rtl/k_secretary_online_selector.sv
sim/kso_checker.sv
sim/testbench.sv
